### rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/bau2x_pkg.sv
package bau2x_pkg;

  localparam int unsigned MaxWidthDefault = 1024;

  localparam int unsigned FwW      = 11;
  localparam int unsigned FhW      = 12;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned RowW     = 13;
  localparam int unsigned ColW     = 11;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned SumW     = 10;
  localparam int unsigned PixW     = 24;

  localparam logic [FwW-1:0] FwReset = 11'd640;
  localparam logic [FhW-1:0] FhReset = 12'd480;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0]          cur;
    logic [PixW-1:0]          left;
    logic [2:0][RowW-1:0]     rows;
    logic [2:0][ColW-1:0]     cols;
    logic [1:0]               row_end;
    logic [1:0]               col_end;
    logic                     row_pair;
    logic                     col_pair;
  } pix_item_t;

  // Box sum of up to four samples, scaled to mean times four.
  function automatic logic [SumW-1:0] box_chan(input logic [ChanW-1:0] cur,
                                               input logic [ChanW-1:0] left,
                                               input logic [ChanW-1:0] up,
                                               input logic [ChanW-1:0] ul,
                                               input logic             rp,
                                               input logic             cp);
    logic [SumW-1:0] s;
    logic [SumW-1:0] res;
    s = SumW'(cur);
    if (cp) begin
      s = s + SumW'(left);
    end
    if (rp) begin
      s = s + SumW'(up);
      if (cp) begin
        s = s + SumW'(ul);
      end
    end
    unique case ({rp, cp})
      2'b11:   res = s;
      2'b00:   res = s << 2;
      default: res = s << 1;
    endcase
    return res;
  endfunction

endpackage

### rtl/box_average_upscale_2x.sv
// Path: an input pixel passes stage A, stage B and the result register in turn.
// Throughput: one result per cycle while the output is not stalled; an input pixel
// has 1 to 9 results (4 on average), walked in turn by the single result generator.
// Reset: asynchronous, active low; counters, left pixel and valids clear,
// frame size returns to 640 x 480. The line store is not cleared.
`include "assert_macros.svh"

module box_average_upscale_2x #(
  parameter int unsigned MAX_WIDTH = bau2x_pkg::MaxWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bau2x_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bau2x_pkg::CfgDataW-1:0] cfg_data_i,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bau2x_pkg::ChanW-1:0]    red_in_i,
  input  logic [bau2x_pkg::ChanW-1:0]    green_in_i,
  input  logic [bau2x_pkg::ChanW-1:0]    blue_in_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bau2x_pkg::RowW-1:0]     out_row_o,
  output logic [bau2x_pkg::ColW-1:0]     out_col_o,
  output logic [bau2x_pkg::SumW-1:0]     red_out_o,
  output logic [bau2x_pkg::SumW-1:0]     green_out_o,
  output logic [bau2x_pkg::SumW-1:0]     blue_out_o,
  output logic                           last_of_run_o
);

  import bau2x_pkg::*;

  localparam int unsigned CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CmpW = ((CW > FwW) ? CW : FwW) + 1;
  localparam logic [FwW-1:0] WClamp = FwW'((MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH);

  // Configuration
  logic [FwW-1:0] frame_width_q;
  logic [FhW-1:0] frame_height_q;
  logic [FwW-1:0] w_eff;
  logic [FhW-1:0] h_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FwReset;
      frame_height_q <= FhReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgFrameWidth:  frame_width_q  <= cfg_data_i[FwW-1:0];
        CfgFrameHeight: frame_height_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    if (frame_width_q < FwW'(2)) begin
      w_eff = FwW'(2);
    end else if (frame_width_q > WClamp) begin
      w_eff = WClamp;
    end else begin
      w_eff = frame_width_q;
    end
    h_eff = (frame_height_q < FhW'(2)) ? FhW'(2) : frame_height_q;
  end

  // Handshake
  logic a_v_q, a_fresh_q;
  logic b_v_q;
  logic o_v_q;
  logic o_ready, b_last, b_done, b_free, a_move, a_free, in_acc;

  assign o_ready    = !o_v_q || !out_stall_i;
  assign b_done     = b_v_q && b_last && o_ready;
  assign b_free     = !b_v_q || b_done;
  assign a_move     = a_v_q && b_free;
  assign a_free     = !a_v_q || a_move;
  assign in_stall_o = !a_free;
  assign in_acc     = in_valid_i && a_free;

  // Position of the incoming pixel
  logic [CW-1:0]   col_cnt_q, col_d, col_now;
  logic [FhW-1:0]  row_cnt_q, row_d, row_now;
  logic [RowW-1:0] row_t;
  logic [CmpW-1:0] w_ext, col_nx;
  logic            col_last, row_last, r_zero, c_zero;

  assign w_ext = CmpW'(w_eff);

  always_comb begin
    row_t   = {1'b0, row_cnt_q};
    col_now = col_cnt_q;
    if (CmpW'(col_cnt_q) >= w_ext) begin
      col_now = '0;
      row_t   = row_t + RowW'(1);
    end
    if (row_t >= {1'b0, h_eff}) begin
      row_t = '0;
    end
    row_now  = row_t[FhW-1:0];
    col_nx   = CmpW'(col_now) + CmpW'(1);
    col_last = (col_nx == w_ext);
    row_last = (({1'b0, row_now} + RowW'(1)) == {1'b0, h_eff});
    r_zero   = (row_now == '0);
    c_zero   = (col_now == '0);
    if (col_last) begin
      col_d = '0;
      row_d = row_last ? '0 : row_now + FhW'(1);
    end else begin
      col_d = col_nx[CW-1:0];
      row_d = row_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_acc) begin
      col_cnt_q <= col_d;
      row_cnt_q <= row_d;
    end
  end

  // Item built at transfer
  pix_item_t       item_d;
  logic [PixW-1:0] left_q;
  logic [RowW-1:0] row2h;
  logic [11:0]     c12, c2, c2m1, w2m1;

  always_comb begin
    row2h = {h_eff, 1'b0} - RowW'(1);
    c12   = 12'(col_now);
    c2    = {c12[10:0], 1'b0};
    c2m1  = c2 - 12'd1;
    w2m1  = {1'b0, w_eff} + {1'b0, w_eff} - 12'd1;

    item_d.cur      = {red_in_i, green_in_i, blue_in_i};
    item_d.left     = left_q;
    item_d.rows[0]  = r_zero ? '0 : {row_now, 1'b0} - RowW'(1);
    item_d.rows[1]  = r_zero ? row2h : {row_now, 1'b0};
    item_d.rows[2]  = row2h;
    item_d.cols[0]  = c_zero ? '0 : c2m1[ColW-1:0];
    item_d.cols[1]  = c_zero ? w2m1[ColW-1:0] : c2[ColW-1:0];
    item_d.cols[2]  = w2m1[ColW-1:0];
    item_d.row_end  = 2'({1'b0, !r_zero}) + 2'({1'b0, row_last});
    item_d.col_end  = 2'({1'b0, !c_zero}) + 2'({1'b0, col_last});
    item_d.row_pair = !r_zero;
    item_d.col_pair = !c_zero;
  end

  // Line store: previous row, one entry per column
  logic [PixW-1:0] line_mem [MAX_WIDTH];
  logic [PixW-1:0] mem_rd_q;
  logic            pend_q;
  logic [CW-1:0]   pend_addr_q;
  logic            mem_we;
  logic [CW-1:0]   mem_waddr;

  assign mem_we    = pend_q || (in_acc && !c_zero);
  assign mem_waddr = pend_q ? pend_addr_q : col_now - CW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= left_q;
    end
    if (in_acc) begin
      mem_rd_q <= line_mem[col_now];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      left_q <= '0;
    end else begin
      pend_q <= in_acc && col_last;
      if (in_acc) begin
        left_q <= item_d.cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && col_last) begin
      pend_addr_q <= col_now;
    end
  end

  // Stage A: item waiting for its line store word
  pix_item_t       a_item_q;
  logic [PixW-1:0] a_up_q, up_now;

  assign up_now = a_fresh_q ? mem_rd_q : a_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      a_fresh_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_q <= in_valid_i;
      end
      a_fresh_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_item_q <= item_d;
    end
    a_up_q <= up_now;
  end

  // Stage B: walks the result list of one item
  pix_item_t       b_item_q;
  logic [PixW-1:0] b_up_q, b_ul_q, up_prev_q;
  logic [1:0]      b_i_q, b_j_q;
  logic            b_row_last, b_col_last, b_rp, b_cp;

  assign b_row_last = (b_i_q == b_item_q.row_end);
  assign b_col_last = (b_j_q == b_item_q.col_end);
  assign b_last     = b_row_last && b_col_last;
  assign b_rp       = b_item_q.row_pair && (b_i_q != 2'd2);
  assign b_cp       = b_item_q.col_pair && (b_j_q != 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      b_i_q <= '0;
      b_j_q <= '0;
    end else if (b_free) begin
      b_v_q <= a_move;
      b_i_q <= '0;
      b_j_q <= '0;
    end else if (o_ready) begin
      if (b_col_last) begin
        b_j_q <= '0;
        b_i_q <= b_i_q + 2'd1;
      end else begin
        b_j_q <= b_j_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_item_q  <= a_item_q;
      b_up_q    <= up_now;
      b_ul_q    <= up_prev_q;
      up_prev_q <= up_now;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_ready) begin
      o_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && b_v_q) begin
      out_row_o     <= b_item_q.rows[b_i_q];
      out_col_o     <= b_item_q.cols[b_j_q];
      red_out_o     <= box_chan(b_item_q.cur[23:16], b_item_q.left[23:16],
                                b_up_q[23:16], b_ul_q[23:16], b_rp, b_cp);
      green_out_o   <= box_chan(b_item_q.cur[15:8], b_item_q.left[15:8],
                                b_up_q[15:8], b_ul_q[15:8], b_rp, b_cp);
      blue_out_o    <= box_chan(b_item_q.cur[7:0], b_item_q.left[7:0],
                                b_up_q[7:0], b_ul_q[7:0], b_rp, b_cp);
      last_of_run_o <= b_last;
    end
  end

  assign out_valid_o = o_v_q;

  `ASSERT_ON(a_deferred_write_free, pend_q |-> !(in_acc && !c_zero), "line store write collision")
  `ASSERT_ON(a_walk_in_list, b_v_q |-> (b_i_q <= b_item_q.row_end && b_j_q <= b_item_q.col_end), "result walk beyond list")
  `ASSERT_ON(a_read_tracked, in_acc |=> (a_v_q && a_fresh_q), "line store read not tracked")
  `ASSERT_ALWAYS(a_fresh_has_item, a_fresh_q |-> a_v_q, "read data without item")

endmodule
